[rtl/tcsdl_pkg.sv]
package tcsdl_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int LEN_W      = 13;
	localparam int GAIN_W     = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_ADDR_W = 3;

	localparam int DEFAULT_STORE_DEPTH = 4096;

	// shared multiplier: signed operand times unsigned gain
	localparam int MUL_A_W = 27;
	localparam int MUL_P_W = MUL_A_W + GAIN_W + 1;
	localparam int SUM_W   = 26;
	localparam int ACC_W   = 58;
	localparam int W_W     = 41;
	localparam int W_LO_W  = 20;

	localparam int MIX_SHIFT = 16;
	localparam int OUT_SHIFT = 31;
	localparam int UPD_SHIFT = 15;

	localparam logic [GAIN_W-1:0] UNITY     = 16'd32768;
	localparam logic [GAIN_W-1:0] WET_SCALE = 16'd21627;

	localparam logic signed [ACC_W-1:0]   ACC_HALF  = ACC_W'(2**(OUT_SHIFT - 1));
	localparam logic signed [MUL_P_W-1:0] PROD_HALF = MUL_P_W'(2**(UPD_SHIFT - 1));

	localparam logic signed [31:0] SAT_MAX = 32'sd8388607;
	localparam logic signed [31:0] SAT_MIN = -32'sd8388608;

	localparam logic [LEN_W-1:0]  LENGTH_A_RST = 13'd1000;
	localparam logic [LEN_W-1:0]  LENGTH_B_RST = 13'd1200;
	localparam logic [LEN_W-1:0]  LENGTH_C_RST = 13'd900;
	localparam logic [GAIN_W-1:0] GAIN_RST     = 16'd26214;
	localparam logic [GAIN_W-1:0] DRY_MIX_RST  = 16'd16384;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_LENGTH_A = 3'd0,
		REG_LENGTH_B = 3'd1,
		REG_LENGTH_C = 3'd2,
		REG_GAIN_A   = 3'd3,
		REG_GAIN_B   = 3'd4,
		REG_GAIN_C   = 3'd5,
		REG_DRY_MIX  = 3'd6
	} reg_idx_t;

	function automatic logic [GAIN_W-1:0] clamp_unity(input logic [GAIN_W-1:0] g);
		return (g > UNITY) ? UNITY : g;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [31:0] v);
		if (v > SAT_MAX) begin
			return SAMPLE_W'(SAT_MAX);
		end
		if (v < SAT_MIN) begin
			return SAMPLE_W'(SAT_MIN);
		end
		return SAMPLE_W'(v);
	endfunction

endpackage

[rtl/tcsdl_store.sv]
module tcsdl_store #(
	parameter int DEPTH = tcsdl_pkg::DEFAULT_STORE_DEPTH,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [ADDR_W-1:0]                      wr_addr,
	input  logic signed [tcsdl_pkg::SAMPLE_W-1:0]  wr_data,
	input  logic [ADDR_W-1:0]                      rd_addr,
	output logic signed [tcsdl_pkg::SAMPLE_W-1:0]  rd_data
);

	logic signed [tcsdl_pkg::SAMPLE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

[rtl/triple_comb_shared_delay_line_top.sv]
// Bank of three feedback combs sharing one delay store.
// Input channel: in_valid / in_stall carrying sample_in and frame_end; an item
// is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall carrying sample_out and frame_end_out,
// one result per input item, held steady while out_stall is high.
// Configuration: cfg_we writes cfg_data into register cfg_addr (0..6: lengths
// a, b, c, gains a, b, c, dry mix); write only while no item is in flight.
// Schedule: one shared multiplier runs seven products per item in sequence,
// together with three store reads and three store writes. out_valid rises
// as the sequencer leaves its final step, and the block takes the next item
// only after the sequencer is back in idle.
// The result register frees the input side: a new item can be taken while
// the previous result still waits. If that result is still stalled when the
// next one is finished, the sequencer waits in its last step.
// Reset: registers return to their defaults, cursors go to zero and the store
// is swept to zero, one entry per cycle, over all STORE_DEPTH entries; in_stall
// stays high during the sweep, configuration writes are taken as usual.
module triple_comb_shared_delay_line_top #(
	parameter int STORE_DEPTH = tcsdl_pkg::DEFAULT_STORE_DEPTH
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [tcsdl_pkg::CFG_ADDR_W-1:0]          cfg_addr,
	input  logic [tcsdl_pkg::CFG_W-1:0]               cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic signed [tcsdl_pkg::SAMPLE_W-1:0]     sample_in,
	input  logic                                      frame_end,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [tcsdl_pkg::SAMPLE_W-1:0]     sample_out,
	output logic                                      frame_end_out
);

	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CMP_W  = (ADDR_W + 1 > tcsdl_pkg::LEN_W) ? ADDR_W + 1 : tcsdl_pkg::LEN_W;
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_RB, S_RC, S_SUM, S_W, S_HI, S_LO, S_OUT, S_RND,
		S_GA, S_UA, S_GB, S_UB, S_GC, S_UC, S_DONE
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] cur_a_q, cur_b_q, cur_c_q;

	logic [tcsdl_pkg::LEN_W-1:0]  length_a_q, length_b_q, length_c_q;
	logic [tcsdl_pkg::GAIN_W-1:0] gain_a_q, gain_b_q, gain_c_q, dry_mix_q;

	logic signed [tcsdl_pkg::SAMPLE_W-1:0] x_q, d0_q, d1_q, d2_q;
	logic signed [tcsdl_pkg::SAMPLE_W-1:0] new_a_q, new_b_q, y_q;
	logic                                  fe_q;
	logic                                  eq_ba_q, eq_ca_q, eq_cb_q;
	logic signed [tcsdl_pkg::SUM_W-1:0]    sum_q;
	logic [tcsdl_pkg::W_LO_W-1:0]          w_lo_q;
	logic signed [tcsdl_pkg::ACC_W-1:0]    acc_q;
	logic signed [tcsdl_pkg::MUL_P_W-1:0]  mul_p_q;

	logic                                  out_valid_q;
	logic signed [tcsdl_pkg::SAMPLE_W-1:0] sample_out_q;
	logic                                  frame_end_out_q;

	logic signed [tcsdl_pkg::MUL_A_W-1:0]  mul_a;
	logic [tcsdl_pkg::GAIN_W-1:0]          mul_b;
	logic [tcsdl_pkg::GAIN_W-1:0]          mix_c, wet;
	logic signed [tcsdl_pkg::SAMPLE_W-1:0] upd_val;

	logic                                  wr_en;
	logic [ADDR_W-1:0]                     wr_addr;
	logic signed [tcsdl_pkg::SAMPLE_W-1:0] wr_data;
	logic [ADDR_W-1:0]                     rd_addr;
	logic signed [tcsdl_pkg::SAMPLE_W-1:0] rd_data;

	function automatic logic [ADDR_W-1:0] next_cursor(input logic [ADDR_W-1:0] cur,
			input logic [tcsdl_pkg::LEN_W-1:0] len);
		logic [CMP_W-1:0] nxt;
		nxt = CMP_W'(cur) + CMP_W'(1);
		if (nxt >= CMP_W'(len) || nxt >= CMP_W'(STORE_DEPTH)) begin
			return '0;
		end
		return nxt[ADDR_W-1:0];
	endfunction

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = out_valid_q;
	assign sample_out    = sample_out_q;
	assign frame_end_out = frame_end_out_q;

	assign mix_c = tcsdl_pkg::clamp_unity(dry_mix_q);
	assign wet   = tcsdl_pkg::UNITY - mix_c;

	// comb update: in + round(entry * gain / 2^15), saturated
	assign upd_val = tcsdl_pkg::sat_sample(
		32'((mul_p_q + tcsdl_pkg::PROD_HALF) >>> tcsdl_pkg::UPD_SHIFT) + 32'(x_q));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_a_q <= tcsdl_pkg::LENGTH_A_RST;
			length_b_q <= tcsdl_pkg::LENGTH_B_RST;
			length_c_q <= tcsdl_pkg::LENGTH_C_RST;
			gain_a_q   <= tcsdl_pkg::GAIN_RST;
			gain_b_q   <= tcsdl_pkg::GAIN_RST;
			gain_c_q   <= tcsdl_pkg::GAIN_RST;
			dry_mix_q  <= tcsdl_pkg::DRY_MIX_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tcsdl_pkg::REG_LENGTH_A: length_a_q <= cfg_data[tcsdl_pkg::LEN_W-1:0];
				tcsdl_pkg::REG_LENGTH_B: length_b_q <= cfg_data[tcsdl_pkg::LEN_W-1:0];
				tcsdl_pkg::REG_LENGTH_C: length_c_q <= cfg_data[tcsdl_pkg::LEN_W-1:0];
				tcsdl_pkg::REG_GAIN_A:   gain_a_q   <= cfg_data;
				tcsdl_pkg::REG_GAIN_B:   gain_b_q   <= cfg_data;
				tcsdl_pkg::REG_GAIN_C:   gain_c_q   <= cfg_data;
				tcsdl_pkg::REG_DRY_MIX:  dry_mix_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_RB: begin
				mul_a = tcsdl_pkg::MUL_A_W'(x_q);
				mul_b = mix_c;
			end
			S_W: begin
				mul_a = tcsdl_pkg::MUL_A_W'(sum_q);
				mul_b = tcsdl_pkg::WET_SCALE;
			end
			S_HI: begin
				mul_a = tcsdl_pkg::MUL_A_W'(signed'(mul_p_q[tcsdl_pkg::W_W-1:tcsdl_pkg::W_LO_W]));
				mul_b = wet;
			end
			S_LO: begin
				mul_a = tcsdl_pkg::MUL_A_W'({1'b0, w_lo_q});
				mul_b = wet;
			end
			S_GA: begin
				mul_a = tcsdl_pkg::MUL_A_W'(d0_q);
				mul_b = tcsdl_pkg::clamp_unity(gain_a_q);
			end
			S_GB: begin
				// comb b sees comb a's write when the cursors meet
				mul_a = tcsdl_pkg::MUL_A_W'(eq_ba_q ? new_a_q : d1_q);
				mul_b = tcsdl_pkg::clamp_unity(gain_b_q);
			end
			S_GC: begin
				if (eq_cb_q) begin
					mul_a = tcsdl_pkg::MUL_A_W'(new_b_q);
				end else if (eq_ca_q) begin
					mul_a = tcsdl_pkg::MUL_A_W'(new_a_q);
				end else begin
					mul_a = tcsdl_pkg::MUL_A_W'(d2_q);
				end
				mul_b = tcsdl_pkg::clamp_unity(gain_c_q);
			end
			default: ;
		endcase
	end

	// store ports
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_c_q;
		wr_data = upd_val;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_UA: begin
				wr_en   = 1'b1;
				wr_addr = cur_a_q;
			end
			S_UB: begin
				wr_en   = 1'b1;
				wr_addr = cur_b_q;
			end
			S_UC: begin
				wr_en   = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_IDLE:  rd_addr = cur_a_q;
			S_RB:    rd_addr = cur_b_q;
			default: rd_addr = cur_c_q;
		endcase
	end

	tcsdl_store #(
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		mul_p_q <= tcsdl_pkg::MUL_P_W'(mul_a * signed'({1'b0, mul_b}));
		if (state_q == S_IDLE && in_valid) begin
			x_q  <= sample_in;
			fe_q <= frame_end;
		end
		unique case (state_q)
			S_RB: begin
				d0_q    <= rd_data;
				eq_ba_q <= (cur_b_q == cur_a_q);
				eq_ca_q <= (cur_c_q == cur_a_q);
				eq_cb_q <= (cur_c_q == cur_b_q);
			end
			S_RC: begin
				d1_q  <= rd_data;
				acc_q <= tcsdl_pkg::ACC_W'(mul_p_q) <<< tcsdl_pkg::MIX_SHIFT;
			end
			S_SUM: begin
				d2_q  <= rd_data;
				sum_q <= tcsdl_pkg::SUM_W'(d0_q) + tcsdl_pkg::SUM_W'(d1_q)
					+ tcsdl_pkg::SUM_W'(rd_data);
			end
			S_HI: begin
				w_lo_q <= mul_p_q[tcsdl_pkg::W_LO_W-1:0];
			end
			S_LO: begin
				acc_q <= acc_q + (tcsdl_pkg::ACC_W'(mul_p_q) <<< tcsdl_pkg::W_LO_W);
			end
			S_OUT: begin
				acc_q <= acc_q + tcsdl_pkg::ACC_W'(mul_p_q);
			end
			S_RND: begin
				y_q <= tcsdl_pkg::sat_sample(
					32'((acc_q + tcsdl_pkg::ACC_HALF) >>> tcsdl_pkg::OUT_SHIFT));
			end
			S_UA: new_a_q <= upd_val;
			S_UB: new_b_q <= upd_val;
			default: ;
		endcase
	end

	// sequencer, cursors and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			clr_q           <= '0;
			cur_a_q         <= '0;
			cur_b_q         <= '0;
			cur_c_q         <= '0;
			out_valid_q     <= 1'b0;
			sample_out_q    <= '0;
			frame_end_out_q <= 1'b0;
		end else begin
			// the final step reloads the result register itself
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RB;
					end
				end
				S_RB:  state_q <= S_RC;
				S_RC:  state_q <= S_SUM;
				S_SUM: state_q <= S_W;
				S_W:   state_q <= S_HI;
				S_HI:  state_q <= S_LO;
				S_LO:  state_q <= S_OUT;
				S_OUT: state_q <= S_RND;
				S_RND: state_q <= S_GA;
				S_GA:  state_q <= S_UA;
				S_UA: begin
					cur_a_q <= next_cursor(cur_a_q, length_a_q);
					state_q <= S_GB;
				end
				S_GB:  state_q <= S_UB;
				S_UB: begin
					cur_b_q <= next_cursor(cur_b_q, length_b_q);
					state_q <= S_GC;
				end
				S_GC:  state_q <= S_UC;
				S_UC: begin
					cur_c_q <= next_cursor(cur_c_q, length_c_q);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q     <= 1'b1;
						sample_out_q    <= y_q;
						frame_end_out_q <= fe_q;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the final step");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> state_q == S_DONE)
		else $error("finished item left while the result register was full");

	a_cursor_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UA |=> (cur_a_q == '0 || CMP_W'(cur_a_q) < CMP_W'(length_a_q)))
		else $error("cursor a advanced past its length");

	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && $past(state_q) == S_CLEAR) |-> $past(clr_q) == CLR_LAST)
		else $error("store sweep ended early");

endmodule

[tb/triple_comb_shared_delay_line_top_test.sv]
module triple_comb_shared_delay_line_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tcsdl_pkg::*;

	localparam int DEPTH = DEFAULT_STORE_DEPTH;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_PHASES = 6;
	localparam int RAND_PER_PHASE = 180;
	localparam int WRAP_ITEMS = 200;
	localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7fffff;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       fe;
	} audio_item_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0]        cfg_addr = '0;
	logic [CFG_W-1:0]             cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic signed [SAMPLE_W-1:0]   sample_in = '0;
	logic                         frame_end = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0]   sample_out;
	logic                         frame_end_out;

	triple_comb_shared_delay_line_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.frame_end_out(frame_end_out)
	);

	always #4 clk = ~clk;

	// predictor copy of the delay store, cursors and registers
	logic signed [SAMPLE_W-1:0] echo_m [DEPTH];
	logic [11:0]                cur_m [3];
	logic [LEN_W-1:0]           len_m [3];
	logic [GAIN_W-1:0]          gain_m [3];
	logic [GAIN_W-1:0]          mix_m;

	audio_item_t sample_feed_q [$];
	audio_item_t mixed_due_q [$];

	int fault_count = 0;
	int hold_cnt = 0;
	bit hold_req = 1'b0;
	bit no_gaps = 1'b0;

	function automatic logic signed [SAMPLE_W-1:0] clip24(input longint v);
		if (v > longint'(SAT_MAX)) begin
			return SAMPLE_W'(SAT_MAX);
		end
		if (v < longint'(SAT_MIN)) begin
			return SAMPLE_W'(SAT_MIN);
		end
		return SAMPLE_W'(v);
	endfunction

	function automatic logic [GAIN_W-1:0] cap_unity(input logic [GAIN_W-1:0] g);
		return (g > UNITY) ? UNITY : g;
	endfunction

	// output mix from the old store contents, then the three ordered comb writes
	task automatic mix_and_feed(input logic signed [SAMPLE_W-1:0] x, input logic fe);
		longint sum, acc, prod, fb;
		logic [GAIN_W-1:0] m;
		int idx, nxt;
		sum = longint'(echo_m[cur_m[0]]) + longint'(echo_m[cur_m[1]])
			+ longint'(echo_m[cur_m[2]]);
		m = cap_unity(mix_m);
		acc = longint'(x) * longint'(m) * 65536
			+ sum * longint'(WET_SCALE) * (longint'(UNITY) - longint'(m));
		mixed_due_q.push_back(audio_item_t'{clip24((acc + (64'sd1 <<< 30)) >>> 31), fe});
		for (int j = 0; j < 3; j++) begin
			idx = cur_m[j];
			prod = longint'(echo_m[idx]) * longint'(cap_unity(gain_m[j]));
			fb = (prod + (64'sd1 <<< 14)) >>> 15;
			echo_m[idx] = clip24(longint'(x) + fb);
			nxt = idx + 1;
			if (nxt >= len_m[j] || nxt >= DEPTH) begin
				nxt = 0;
			end
			cur_m[j] = 12'(nxt);
		end
	endtask

	task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		case (addr)
			REG_LENGTH_A: len_m[0] = data[LEN_W-1:0];
			REG_LENGTH_B: len_m[1] = data[LEN_W-1:0];
			REG_LENGTH_C: len_m[2] = data[LEN_W-1:0];
			REG_GAIN_A:   gain_m[0] = data;
			REG_GAIN_B:   gain_m[1] = data;
			REG_GAIN_C:   gain_m[2] = data;
			REG_DRY_MIX:  mix_m = data;
			default: ;
		endcase
	endtask

	task automatic apply_setup(input logic [CFG_W-1:0] la, lb, lc, ga, gb, gc, mx, stray);
		put_reg(REG_LENGTH_A, la);
		put_reg(REG_LENGTH_B, lb);
		put_reg(REG_LENGTH_C, lc);
		put_reg(REG_GAIN_A, ga);
		put_reg(REG_GAIN_B, gb);
		put_reg(REG_GAIN_C, gc);
		put_reg(REG_DRY_MIX, mx);
		put_reg(REG_NONE, stray);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// upper bits above the 13-bit length are random and must be dropped
	function automatic logic [CFG_W-1:0] pick_length();
		logic [LEN_W-1:0] l;
		case ($urandom_range(0, 7))
			0: l = 13'd1;
			1: l = 13'd4096;
			2: l = 13'($urandom);
			3: l = 13'd0;
			default: l = 13'($urandom_range(1, 48));
		endcase
		return {3'($urandom), l};
	endfunction

	function automatic logic [CFG_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return UNITY;
			2: return 16'($urandom);
			default: return 16'($urandom_range(16000, 32768));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_mix();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return UNITY;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return S_MAX;
			1: return S_MIN;
			2, 3, 4: return 24'($signed($urandom_range(0, 2000)) - 1000);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic push_item(input logic signed [SAMPLE_W-1:0] s, input logic fe);
		sample_feed_q.push_back(audio_item_t'{s, fe});
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++) begin
			push_item(rand_sample(), 1'($urandom));
		end
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (sample_feed_q.size() != 0 || in_valid || mixed_due_q.size() != 0);
	endtask

	// sender: predict on acceptance, then offer the next item or idle
	always @(posedge clk) begin : sender
		audio_item_t it;
		logic took;
		took = in_valid && !in_stall;
		if (took) begin
			mix_and_feed(sample_in, frame_end);
		end
		if (arst_n && (!in_valid || took)) begin
			if (sample_feed_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 17)) begin
				it = sample_feed_q.pop_front();
				in_valid <= 1'b1;
				sample_in <= it.sample;
				frame_end <= it.fe;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: check each accepted item, drive stall
	always @(posedge clk) begin : receiver
		audio_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (mixed_due_q.size() == 0) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("unexpected output item: sample_out %0d frame_end_out %0b",
							sample_out, frame_end_out);
					end
				end else begin
					want = mixed_due_q.pop_front();
					if (sample_out !== want.sample || frame_end_out !== want.fe) begin
						fault_count++;
						if (fault_count <= 10) begin
							$display("mismatch: sample_out exp %0d got %0d, frame_end_out exp %0b got %0b",
								want.sample, sample_out, want.fe, frame_end_out);
						end
					end
				end
			end
			if (hold_req) begin
				hold_cnt = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !no_gaps && ($urandom_range(0, 99) < 17);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("triple_comb_shared_delay_line_top_test failed");
		$finish;
	end

	initial begin : stimulus
		for (int i = 0; i < DEPTH; i++) begin
			echo_m[i] = '0;
		end
		for (int j = 0; j < 3; j++) begin
			cur_m[j] = '0;
			gain_m[j] = GAIN_RST;
		end
		len_m[0] = LENGTH_A_RST;
		len_m[1] = LENGTH_B_RST;
		len_m[2] = LENGTH_C_RST;
		mix_m = DRY_MIX_RST;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, field extremes
		push_item('0, 1'b0);
		push_item(S_MAX, 1'b1);
		push_item(S_MIN, 1'b0);
		push_item(-24'sd1, 1'b1);
		push_item(24'sd1, 1'b0);
		push_item(S_MAX, 1'b0);
		wait_idle();

		// all cursors on entry zero, gains at and above unity, fully wet;
		// lowering the lengths also drops cursors that sit beyond them
		apply_setup(16'd1, 16'd1, 16'd1, UNITY, 16'hffff, 16'd40000, 16'd0, 16'h1234);
		for (int i = 0; i < 4; i++) begin
			push_item(S_MAX, 1'(i));
		end
		for (int i = 0; i < 4; i++) begin
			push_item(S_MIN, 1'(i));
		end
		push_item('0, 1'b1);
		wait_idle();

		// zero length, length past the store, dry mix above unity
		apply_setup(16'd0, 16'hffff, 16'd2, 16'd0, 16'd1, 16'd32767, 16'hffff, 16'hffff);
		push_item(S_MAX, 1'b1);
		push_item(S_MIN, 1'b0);
		push_item(S_MAX, 1'b0);
		push_item(S_MIN, 1'b1);
		push_item(24'sd12345, 1'b0);
		push_item(-24'sd12345, 1'b1);
		wait_idle();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			apply_setup(pick_length(), pick_length(), pick_length(),
				pick_gain(), pick_gain(), pick_gain(), pick_mix(), 16'($urandom));
			no_gaps = (ph == 2);
			queue_random(RAND_PER_PHASE);
			// long output hold-off while the sender keeps offering
			if (ph == 3) begin
				hold_req = 1'b1;
			end
			wait_idle();
		end

		// lengths at and beyond the store size
		apply_setup(16'd4096, 16'hffff, 16'd5000,
			pick_gain(), pick_gain(), pick_gain(), pick_mix(), 16'($urandom));
		no_gaps = 1'b1;
		queue_random(WRAP_ITEMS);
		wait_idle();
		no_gaps = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		fault_count += mixed_due_q.size();
		if (fault_count == 0) begin
			$display("triple_comb_shared_delay_line_top_test passed");
		end else begin
			$display("triple_comb_shared_delay_line_top_test failed");
		end
		$finish;
	end

endmodule
